/* design/dtfp_pkg.sv */
// ----------------------------------------------------------------------------
// dtfp_pkg - shared types and constants for the decimal text parser
// Request payload types, result status codes, character codes and the
// power-of-ten table used for scaling and fraction padding.
// ----------------------------------------------------------------------------
`default_nettype none

package dtfp_pkg;

    localparam int FRAC_DIGITS_DEF = 4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] ch;
        logic       no_char;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] tick_value;
        logic [1:0]         status;
    } t_out_item;

    // Parse state of one finished string, handed to the result stage
    typedef struct packed {
        logic [63:0] whole;
        logic [63:0] tick;
        logic [19:0] frac;
        logic        neg;
        logic        saw_digit;
        logic        bad;
        logic        ovf;
    } t_fin;

    function automatic logic [63:0] pow10(input logic [2:0] n);
        logic [63:0] p;
        unique case (n)
            3'd0:    p = 64'd1;
            3'd1:    p = 64'd10;
            3'd2:    p = 64'd100;
            3'd3:    p = 64'd1000;
            3'd4:    p = 64'd10000;
            3'd5:    p = 64'd100000;
            3'd6:    p = 64'd1000000;
            default: p = 64'd10000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* design/decimal_text_to_fixed_point_top.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_top - decimal string to fixed-point parser
// Takes a price string one character per request and returns the signed
// value in ticks (whole * 10^FRAC_DIGITS + fraction) with a status code.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   in      | into      | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//   out     | out of    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// One character request per cycle while o_in_stall is low; a result passes
// from the edge that takes the last character through the input register,
// then the accumulator, then the result register.
// The accumulator's multiply-by-ten and add sets the cycle time.
// A stalled result freezes all three stages together.
// Synchronous active-low reset clears the parse state and all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_fixed_point_top
    import dtfp_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    logic      en;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      fin_valid;
    t_fin      fin;

    // pipeline moves whenever the result register is free or being taken
    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_item <= i_in_item;
        end
    end

    dtfp_accum #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_in_valid),
        .i_item      (r_in_item),
        .o_fin_valid (fin_valid),
        .o_fin       (fin)
    );

    dtfp_finish #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire

/* design/dtfp_accum.sv */
// ----------------------------------------------------------------------------
// dtfp_accum - character accumulator
// Runs the sign/integer/fraction grammar one character per enabled cycle and
// keeps the running magnitude both unscaled (for the overflow rule) and in
// ticks. On the last character it snapshots the state and starts afresh.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfp_accum
    import dtfp_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_fin_valid,
    output t_fin          o_fin
);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_INT   = 2'd1,
        PH_FRAC  = 2'd2
    } t_phase;

    localparam logic [19:0] SCALE     = 20'(pow10(3'(FRAC_DIGITS)));
    localparam logic [2:0]  FRAC_MAX  = 3'(FRAC_DIGITS);
    localparam logic [67:0] TOP       = 68'h0_8000_0000_0000_0000;

    t_phase      r_phase,      n_phase;
    logic        r_neg,        n_neg;
    logic [63:0] r_whole,      n_whole;
    logic [63:0] r_tick,       n_tick;
    logic [19:0] r_frac,       n_frac;
    logic [2:0]  r_frac_cnt,   n_frac_cnt;
    logic        r_saw,        n_saw;
    logic        r_bad,        n_bad;
    logic        r_ovf,        n_ovf;
    logic        r_fin_valid;
    t_fin        r_fin;

    logic        is_digit;
    logic [3:0]  d;
    logic [67:0] whole_x10;
    logic [23:0] int_step;
    logic [63:0] tick_int;
    logic [19:0] frac_step;
    logic [63:0] tick_frac;

    assign is_digit  = (i_item.ch >= CH_ZERO) && (i_item.ch <= CH_NINE);
    assign d         = 4'(i_item.ch - CH_ZERO);
    assign whole_x10 = ({4'b0, r_whole} << 3) + ({4'b0, r_whole} << 1) + 68'(d);
    assign int_step  = 24'(d) * 24'(SCALE);
    assign tick_int  = (r_tick << 3) + (r_tick << 1) + 64'(int_step);
    // weight of the next kept fraction digit: 10^(FRAC_DIGITS - 1 - count)
    assign frac_step = 20'(24'(d) * 24'(pow10(FRAC_MAX - 3'd1 - r_frac_cnt)));
    assign tick_frac = r_tick + 64'(frac_step);

    always_comb begin
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_whole    = r_whole;
        n_tick     = r_tick;
        n_frac     = r_frac;
        n_frac_cnt = r_frac_cnt;
        n_saw      = r_saw;
        n_bad      = r_bad;
        n_ovf      = r_ovf;
        if (!i_item.no_char && !r_bad) begin
            priority if (is_digit) begin
                n_saw = 1'b1;
                if (r_phase == PH_FRAC) begin
                    // surplus fraction digits are dropped
                    if (r_frac_cnt < FRAC_MAX) begin
                        n_frac     = r_frac + frac_step;
                        n_frac_cnt = r_frac_cnt + 3'd1;
                        n_tick     = tick_frac;
                    end
                end else begin
                    n_phase = PH_INT;
                    if (!r_ovf) begin
                        if (whole_x10 > TOP) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_whole = whole_x10[63:0];
                            n_tick  = tick_int;
                        end
                    end
                end
            end else if (i_item.ch == CH_POINT) begin
                if (r_phase == PH_FRAC) begin
                    n_bad = 1'b1;
                end else begin
                    n_phase = PH_FRAC;
                end
            end else if ((i_item.ch == CH_PLUS || i_item.ch == CH_MINUS) &&
                         r_phase == PH_START && !r_saw) begin
                n_neg   = (i_item.ch == CH_MINUS);
                n_phase = PH_INT;
            end else begin
                n_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_neg       <= 1'b0;
            r_whole     <= '0;
            r_tick      <= '0;
            r_frac      <= '0;
            r_frac_cnt  <= '0;
            r_saw       <= 1'b0;
            r_bad       <= 1'b0;
            r_ovf       <= 1'b0;
            r_fin_valid <= 1'b0;
        end else if (i_en) begin
            r_fin_valid <= i_valid && i_item.is_last;
            if (i_valid) begin
                if (i_item.is_last) begin
                    r_phase    <= PH_START;
                    r_neg      <= 1'b0;
                    r_whole    <= '0;
                    r_tick     <= '0;
                    r_frac     <= '0;
                    r_frac_cnt <= '0;
                    r_saw      <= 1'b0;
                    r_bad      <= 1'b0;
                    r_ovf      <= 1'b0;
                end else begin
                    r_phase    <= n_phase;
                    r_neg      <= n_neg;
                    r_whole    <= n_whole;
                    r_tick     <= n_tick;
                    r_frac     <= n_frac;
                    r_frac_cnt <= n_frac_cnt;
                    r_saw      <= n_saw;
                    r_bad      <= n_bad;
                    r_ovf      <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid && i_item.is_last) begin
            r_fin.whole     <= n_whole;
            r_fin.tick      <= n_tick;
            r_fin.frac      <= n_frac;
            r_fin.neg       <= n_neg;
            r_fin.saw_digit <= n_saw;
            r_fin.bad       <= n_bad;
            r_fin.ovf       <= n_ovf;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

`ifndef SYNTHESIS
    a_frac_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_cnt <= FRAC_MAX)
        else $error("fraction digit count beyond kept width");

    a_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid |-> (r_phase == PH_START && !r_saw && !r_bad && !r_ovf))
        else $error("parse state not cleared after last character");

    a_ovf_needs_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_saw && r_phase != PH_START))
        else $error("overflow flagged without integer digits");
`endif

endmodule

`default_nettype wire

/* design/dtfp_finish.sv */
// ----------------------------------------------------------------------------
// dtfp_finish - result stage
// Checks the scaled magnitude against the signed range, applies the sign
// and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfp_finish
    import dtfp_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_fin_valid,
    input  wire t_fin  i_fin,
    output logic       o_valid,
    output t_out_item  o_item
);

    localparam logic [63:0] SCALE = pow10(3'(FRAC_DIGITS));
    localparam logic [63:0] TOP   = 64'h8000_0000_0000_0000;
    // whole*SCALE + frac > limit  <=>  whole > Q, or whole == Q and frac > R
    localparam logic [63:0] Q_POS = (TOP - 64'd1) / SCALE;
    localparam logic [63:0] R_POS = (TOP - 64'd1) % SCALE;
    localparam logic [63:0] Q_NEG = TOP / SCALE;
    localparam logic [63:0] R_NEG = TOP % SCALE;

    logic        r_valid;
    t_out_item   r_item;
    logic [63:0] q;
    logic [63:0] r;
    logic        too_big;
    t_status     status;
    logic [63:0] value;

    assign q       = i_fin.neg ? Q_NEG : Q_POS;
    assign r       = i_fin.neg ? R_NEG : R_POS;
    assign too_big = (i_fin.whole > q) || (i_fin.whole == q && 64'(i_fin.frac) > r);

    always_comb begin
        value = '0;
        priority if (i_fin.bad || !i_fin.saw_digit) begin
            status = ST_MALFORMED;
        end else if (i_fin.ovf || too_big) begin
            status = ST_OVERFLOW;
        end else begin
            status = ST_OK;
            value  = i_fin.neg ? (64'd0 - i_fin.tick) : i_fin.tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_fin_valid) begin
            r_item.tick_value <= $signed(value);
            r_item.status     <= status;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

`ifndef SYNTHESIS
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.status != ST_OK) |-> (r_item.tick_value == 64'sd0))
        else $error("non-zero value with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_item.status == ST_OK || r_item.status == ST_MALFORMED ||
                     r_item.status == ST_OVERFLOW))
        else $error("undefined status code");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_en) |=> (r_valid && $stable(r_item)))
        else $error("result changed while pipeline frozen");
`endif

endmodule

`default_nettype wire
